FILE: hdl/lpht_pkg.sv
// Package: shared types, constants and codes of the linear-probe hash table.
package lpht_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int HASH_W  = 32;
    localparam int LIVE_W  = 7;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam bit SLOTS_POW2 = ((1 << IDX_W) == SLOTS);

    localparam int STEP_W  = 2;
    localparam int MUL_B_W = 17;
    localparam int M_SPLIT = 16;
    localparam int REC_SH  = HASH_W + IDX_W;
    localparam int PROD_W  = REC_SH + HASH_W;
    localparam longint unsigned REC_M =
        ((64'd1 << REC_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [MUL_B_W-1:0] REC_M_LO =
        MUL_B_W'(REC_M & ((64'd1 << M_SPLIT) - 64'd1));
    localparam logic [MUL_B_W-1:0] REC_M_HI = MUL_B_W'(REC_M >> M_SPLIT);

    localparam logic [STEP_W-1:0] STEP_LO  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_HI  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_FIX = 2'd0;

    localparam logic [OP_W-1:0] OP_FIND    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_LIVE    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_mark            mark;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_slot            wr_data;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  found_value;
        logic [LIVE_W-1:0] live_entries;
    } t_result;

endpackage

FILE: hdl/lpht_if.sv
// Interfaces: request and result channels with valid/ready handshake.
interface lpht_req_if;
    logic                     valid;
    logic                     ready;
    logic [lpht_pkg::OP_W-1:0]   op;
    logic [lpht_pkg::KEY_W-1:0]  key;
    logic [lpht_pkg::HASH_W-1:0] key_hash;
    logic [lpht_pkg::VAL_W-1:0]  entry_value;

    modport source (output valid, op, key, key_hash, entry_value, input ready);
    modport sink   (input valid, op, key, key_hash, entry_value, output ready);
endinterface

interface lpht_res_if;
    logic                        valid;
    logic                        ready;
    logic [lpht_pkg::STAT_W-1:0] status;
    logic [lpht_pkg::VAL_W-1:0]  found_value;
    logic [lpht_pkg::LIVE_W-1:0] live_entries;

    modport source (output valid, status, found_value, live_entries, input ready);
    modport sink   (input valid, status, found_value, live_entries, output ready);
endinterface

FILE: hdl/lpht_mem.sv
// Slot store: one write port, one registered read port.
module lpht_mem (
    input  logic               i_clk,
    input  lpht_pkg::t_mem_req i_req,
    output lpht_pkg::t_slot    o_rd_data
);
    import lpht_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: hdl/lpht_ctrl.sv
// Probe sequencer: home-slot reduction, one slot compare per probe, update.
module lpht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lpht_req_if.sink           i_req,
    output lpht_pkg::t_mem_req o_mem,
    input  lpht_pkg::t_slot    i_rd,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output lpht_pkg::t_result  o_res
);
    import lpht_pkg::*;

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VAL_W-1:0]   r_value, n_value;
    logic [HASH_W-1:0]  r_hash, n_hash;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic               r_have_free, n_have_free;
    logic [CNT_W-1:0]   r_live, n_live;
    t_status            r_status, n_status;
    logic [VAL_W-1:0]   r_found, n_found;

    logic                      accept;
    logic [HASH_W-1:0]         quot;
    logic [HASH_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [HASH_W+MUL_B_W-1:0] mul_p;
    logic [IDX_W-1:0]          idx_next;
    logic                      is_empty;
    logic                      is_live;
    logic                      hit;
    logic                      last;
    logic                      stop;
    logic                      free_ok;
    logic [IDX_W-1:0]          free_at;

    assign accept   = i_req.valid && i_req.ready;
    assign quot     = r_prod[PROD_W-1:REC_SH];
    assign mul_a    = (r_step == STEP_FIX) ? quot : r_hash;
    assign mul_b    = (r_step == STEP_LO) ? REC_M_LO :
                      (r_step == STEP_HI) ? REC_M_HI : MUL_B_W'(SLOTS);
    assign mul_p    = {{MUL_B_W{1'b0}}, mul_a} * {{HASH_W{1'b0}}, mul_b};
    assign idx_next = (r_idx == IDX_W'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
    assign is_empty = (i_rd.mark == MARK_EMPTY);
    assign is_live  = (i_rd.mark == MARK_LIVE);
    assign hit      = is_live && (i_rd.key == r_key);
    assign last     = (r_cnt == CNT_W'(SLOTS - 1));
    assign stop     = hit || is_empty || last;
    assign free_ok  = r_have_free || !is_live;
    assign free_at  = r_have_free ? r_free_idx : r_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == IDX_W'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_req.op != OP_FIND && i_req.op != OP_ADD && i_req.op != OP_EXTRACT)
                        n_state = S_DONE;
                    else if (SLOTS_POW2)
                        n_state = S_READ;
                    else
                        n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (r_step == STEP_FIX) n_state = S_READ;
            end
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = stop ? S_DONE : S_READ;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_key       = r_key;
        n_value     = r_value;
        n_hash      = r_hash;
        n_step      = r_step;
        n_prod      = r_prod;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_free_idx  = r_free_idx;
        n_have_free = r_have_free;
        n_live      = r_live;
        n_status    = r_status;
        n_found     = r_found;
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_idx;
        o_mem.wr_data = '{mark: MARK_EMPTY, key: r_key, value: r_value};
        o_mem.rd_addr = r_idx;
        i_req.ready   = 1'b0;
        o_res_valid   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_mem.wr_en = 1'b1;
                n_idx       = idx_next;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op        = i_req.op;
                    n_key       = i_req.key;
                    n_value     = i_req.entry_value;
                    n_hash      = i_req.key_hash;
                    n_step      = STEP_LO;
                    n_cnt       = '0;
                    n_have_free = 1'b0;
                    n_status    = ST_NOT_FOUND;
                    n_found     = '0;
                    n_idx       = SLOTS_POW2 ? i_req.key_hash[IDX_W-1:0] : '0;
                end
            end
            S_HOME: begin
                n_step = r_step - 1'b1;
                case (r_step)
                    STEP_LO: n_prod = PROD_W'(mul_p);
                    STEP_HI: n_prod = r_prod + (PROD_W'(mul_p) << M_SPLIT);
                    default: n_idx  = r_hash[IDX_W-1:0] - mul_p[IDX_W-1:0];
                endcase
            end
            S_CHECK: begin
                if (!r_have_free && !is_live) begin
                    n_have_free = 1'b1;
                    n_free_idx  = r_idx;
                end
                if (!stop) begin
                    n_idx = idx_next;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    case (r_op)
                        OP_FIND: begin
                            if (hit) begin
                                n_status = ST_OK;
                                n_found  = i_rd.value;
                            end
                        end
                        OP_ADD: begin
                            if (hit) begin
                                n_status = ST_DUPLICATE;
                            end else if (free_ok) begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = free_at;
                                o_mem.wr_data = '{mark: MARK_LIVE, key: r_key, value: r_value};
                                n_live        = r_live + 1'b1;
                                n_status      = ST_OK;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_EXTRACT: begin
                            if (hit) begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_data = '{mark: MARK_DELETED, key: r_key,
                                                  value: i_rd.value};
                                if (r_live != '0) n_live = r_live - 1'b1;
                                n_status      = ST_OK;
                                n_found       = i_rd.value;
                            end
                        end
                        default: n_status = ST_NOT_FOUND;
                    endcase
                end
            end
            S_DONE: o_res_valid = 1'b1;
            default: o_res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_live      <= '0;
            r_have_free <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_live      <= n_live;
            r_have_free <= n_have_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_value    <= n_value;
        r_hash     <= n_hash;
        r_step     <= n_step;
        r_prod     <= n_prod;
        r_cnt      <= n_cnt;
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_found    <= n_found;
    end

    assign o_res.status       = r_status;
    assign o_res.found_value  = r_found;
    assign o_res.live_entries = LIVE_W'(r_live);
endmodule

FILE: hdl/linear_probe_hash_table_core.sv
// Top level: slot store, probe sequencer and result output register.
// Home slot: the low hash bits for a power-of-two slot count; otherwise reduced
//   by a reciprocal multiply (low half, high half, fix-up) on one shared multiplier.
// Flow: one request at a time; each probed slot is read through the single read
//   port and then checked, until a hit, an empty slot or the last slot.
// Reset: synchronous, active low; then a clearing pass marks every slot empty
//   while the request channel is held not ready.
module linear_probe_hash_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_req_if.sink   i_req,
    lpht_res_if.source o_res
);
    import lpht_pkg::*;

    t_mem_req mem_req;
    t_slot    rd_data;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    logic     r_out_valid;
    t_result  r_out;

    lpht_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rd        (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.found_value  = r_out.found_value;
    assign o_res.live_entries = r_out.live_entries;
endmodule

FILE: hdl/lpht_checker.sv
// Checker: port-level assertions on the hash table core, bound to the top level.
module lpht_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [lpht_pkg::STAT_W-1:0] i_status,
    input logic [lpht_pkg::VAL_W-1:0]  i_found_value,
    input logic [lpht_pkg::LIVE_W-1:0] i_live_entries
);
    import lpht_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while a request is in progress");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_live_entries <= LIVE_W'(SLOTS)))
        else $error("live count exceeds slot count");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_found_value == '0))
        else $error("nonzero value on a failed request");
endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_found_value  (o_res.found_value),
    .i_live_entries (o_res.live_entries)
);
